>>> src/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled in reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("checker: property failed");

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("checker: property failed");

`endif

>>> src/ows_pkg.sv
// Package for the omni wheel speed command block: types and constants.
`default_nettype none
package ows_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int SCALE_SHIFT = FRAC_BITS + 8;
  localparam int ARM_FRAC    = 12;
  localparam int W_FRAC      = 16;

  localparam logic [16:0] HALF_SQRT3_Q16 = 17'd56756;
  localparam logic [9:0]  MAG_MAX        = 10'd1023;
  localparam logic [1:0]  WHEEL_LAST     = 2'd3;

  localparam logic [14:0] SLEW_STEP_RST    = 15'd4096;
  localparam logic [11:0] ROTATION_ARM_RST = 12'd483;
  localparam logic [14:0] SPEED_LIMIT_RST  = 15'd4096;
  localparam logic [19:0] UNITS_GAIN_RST   = 20'd428878;

  localparam logic [3:0] CFG_SLEW_STEP    = 4'd0;
  localparam logic [3:0] CFG_ROTATION_ARM = 4'd1;
  localparam logic [3:0] CFG_SPEED_LIMIT  = 4'd2;
  localparam logic [3:0] CFG_UNITS_GAIN   = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YAW_MUL,
    ST_SLEW,
    ST_K_MUL,
    ST_WSUM,
    ST_WCLAMP,
    ST_SCALE,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

>>> src/omni_wheel_speed_command.sv
// Top level: three-wheel omni inverse kinematics with slew limit and servo word output.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    forward, lateral, yaw (16b each)
//  m_axis    out  m_axis_tvalid/m_axis_tready    wheel index, speed word, tlast
//  cfg       in   cfg_valid/cfg_ready            register index, write data
//
//  A command is accepted, then its axes and the sine term are formed, then each wheel
//  in turn goes through the shared multiplier; output stalls hold the sequence.
//  s_axis_tready is high only while idle; m_axis holds a word until taken.
//  rst is synchronous: config registers return to defaults, kept axes to zero.
`default_nettype none
module omni_wheel_speed_command
  import ows_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // forward_speed, lateral_speed, yaw_rate
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // wheel_index, speed_word, zero pad
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  state_t state, state_next;

  logic [14:0] slew_step;
  logic [11:0] rotation_arm;
  logic [14:0] speed_limit;
  logic [19:0] units_gain;

  logic signed [15:0] fwd, lat, yaw;
  logic signed [15:0] prev_axis [3];
  logic signed [38:0] prod;
  logic signed [32:0] kp;
  logic signed [35:0] wsum;
  logic [14:0]        mag;
  logic               pos;
  logic [1:0]         wheel;

  logic signed [17:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [38:0] mul_p;

  logic [38:0]        yaw_neg;
  logic [27:0]        yaw_abs;
  logic [15:0]        yaw_rmag;
  logic signed [15:0] tgt0, tgt1, tgt2;

  logic signed [35:0] a1_f, a1_h, a2_f, kp_x, wsum_next;
  logic [35:0]        wabs;
  logic [19:0]        rmag;
  logic [14:0]        cmag;

  logic [35:0]        scl_sum, scl_q;
  logic [9:0]         mag10;
  logic               emit;

  function automatic logic signed [15:0] slew_fn(input logic signed [15:0] tgt,
                                                 input logic signed [15:0] prev,
                                                 input logic [14:0] step);
    logic signed [17:0] d, s, up, dn;
    d  = 18'(tgt) - 18'(prev);
    s  = signed'({3'b000, step});
    up = 18'(prev) + s;
    dn = 18'(prev) - s;
    if (d > s) begin
      return up[15:0];
    end else if (d < -s) begin
      return dn[15:0];
    end
    return tgt;
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    case (state)
      ST_YAW_MUL: begin
        mul_a = 18'(yaw);
        mul_b = signed'({9'd0, rotation_arm});
      end
      ST_K_MUL: begin
        mul_a = 18'(prev_axis[0]);
        mul_b = signed'({4'd0, HALF_SQRT3_Q16});
      end
      default: begin
        mul_a = signed'({3'd0, mag});
        mul_b = signed'({1'b0, units_gain});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    yaw_neg  = 39'(-prod);
    yaw_abs  = prod[38] ? yaw_neg[27:0] : prod[27:0];
    yaw_rmag = 16'((yaw_abs + 28'(1 << (ARM_FRAC - 1))) >> ARM_FRAC);
    tgt0     = lat;
    tgt1     = (fwd == 16'sh8000) ? 16'sh7fff : -fwd;
    tgt2     = prod[38] ? -signed'(yaw_rmag) : signed'(yaw_rmag);
  end

  always_comb begin
    a1_f = 36'(prev_axis[1]) <<< W_FRAC;
    a1_h = 36'(prev_axis[1]) <<< (W_FRAC - 1);
    a2_f = 36'(prev_axis[2]) <<< W_FRAC;
    kp_x = 36'(kp);
    case (wheel)
      2'd0:    wsum_next = a1_f - a2_f;
      2'd1:    wsum_next = -kp_x - a1_h - a2_f;
      default: wsum_next = kp_x - a1_h - a2_f;
    endcase
  end

  always_comb begin
    wabs = wsum[35] ? 36'(-wsum) : 36'(wsum);
    rmag = 20'((wabs + 36'(1 << (W_FRAC - 1))) >> W_FRAC);
    cmag = (rmag > 20'(speed_limit)) ? speed_limit : rmag[14:0];
  end

  always_comb begin
    scl_sum = 36'(prod[34:0]) + 36'(1 << (SCALE_SHIFT - 1));
    scl_q   = scl_sum >> SCALE_SHIFT;
    mag10   = (scl_q > 36'(MAG_MAX)) ? MAG_MAX : scl_q[9:0];
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_YAW_MUL;
        end
      end
      ST_YAW_MUL: state_next = ST_SLEW;
      ST_SLEW:    state_next = ST_K_MUL;
      ST_K_MUL:   state_next = ST_WSUM;
      ST_WSUM:    state_next = ST_WCLAMP;
      ST_WCLAMP:  state_next = ST_SCALE;
      ST_SCALE:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          emit       = 1'b1;
          state_next = (wheel == 2'd2) ? ST_IDLE : ST_WSUM;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slew_step     <= SLEW_STEP_RST;
      rotation_arm  <= ROTATION_ARM_RST;
      speed_limit   <= SPEED_LIMIT_RST;
      units_gain    <= UNITS_GAIN_RST;
      prev_axis[0]  <= '0;
      prev_axis[1]  <= '0;
      prev_axis[2]  <= '0;
      wheel         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLEW_STEP:    slew_step    <= cfg_data[14:0];
          CFG_ROTATION_ARM: rotation_arm <= cfg_data[11:0];
          CFG_SPEED_LIMIT:  speed_limit  <= cfg_data[14:0];
          CFG_UNITS_GAIN:   units_gain   <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_SLEW) begin
        prev_axis[0] <= slew_fn(tgt0, prev_axis[0], slew_step);
        prev_axis[1] <= slew_fn(tgt1, prev_axis[1], slew_step);
        prev_axis[2] <= slew_fn(tgt2, prev_axis[2], slew_step);
        wheel        <= '0;
      end
      if (emit) begin
        wheel         <= wheel + 2'd1;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      fwd <= s_axis_tdata[15:0];
      lat <= s_axis_tdata[31:16];
      yaw <= s_axis_tdata[47:32];
    end
    if (state == ST_YAW_MUL || state == ST_SCALE) begin
      prod <= mul_p;
    end
    if (state == ST_K_MUL) begin
      kp <= mul_p[32:0];
    end
    if (state == ST_WSUM) begin
      wsum <= wsum_next;
    end
    if (state == ST_WCLAMP) begin
      mag <= cmag;
      pos <= !wsum[35] && (cmag != 15'd0);
    end
    if (emit) begin
      m_axis_tdata <= {3'b000, pos, mag10, wheel + 2'd1};
      m_axis_tlast <= (wheel == 2'd2);
    end
  end

endmodule
`default_nettype wire

>>> src/ows_checker.sv
// Port checker for the omni wheel speed command block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ows_checker
  import ows_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  `ASSERT_CLK(a_last_is_third, clk, rst, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1:0] == WHEEL_LAST))
  `ASSERT_CLK(a_word_shape, clk, rst, m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd0 && m_axis_tdata[15:13] == 3'd0))
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `ASSERT_CLK(a_stall_holds, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind omni_wheel_speed_command ows_checker u_ows_checker (.*);
`default_nettype wire
